// ===== rtl/sync_frame_deframer_crc16_defines.svh =====
// Assertion macros for the sync-word deframer.
// Included by the top level; no other dependencies.
`ifndef SYNC_FRAME_DEFRAMER_CRC16_DEFINES_SVH
`define SYNC_FRAME_DEFRAMER_CRC16_DEFINES_SVH

`ifndef SYNTH
// Clocked on clk, held off during rst.
`define SFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sync_frame_deframer_crc16: assertion failed");
// Clocked on clk, checked during reset too.
`define SFD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sync_frame_deframer_crc16: assertion failed");
`else
`define SFD_ASSERT(lbl, prop)
`define SFD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/sfd_pkg.sv =====
// Shared types and constants for the sync-word deframer.
// No dependencies.
package sfd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_CMD,
    PH_INDEX,
    PH_LEN,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
  localparam logic [7:0]  SYNC_SECOND = 8'hA5;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam int TDATA_W = 40;
  localparam int TUSER_W = 2;

endpackage

// ===== rtl/sfd_crc16_byte.sv =====
// One-byte update of the reflected CRC-16/MODBUS register.
// Depends on sfd_pkg.
module sfd_crc16_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import sfd_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/sync_frame_deframer_crc16.sv =====
// Top level of the sync-word deframer with CRC-16/MODBUS check.
// Depends on sfd_pkg, sfd_crc16_byte and sync_frame_deframer_crc16_defines.svh.
//
//  channel  dir  tdata                          tuser     tlast
//  s_axis   in   [7:0] rx_byte                  -         -
//  m_axis   out  cmd/index/len/data/crc_good    out_kind  frame_last
//
// One byte per cycle unless the output stalls; the frame FSM and a byte-wide
// CRC update sit between the input port and the output register, so a result
// appears the cycle after its byte is taken. Sync, command, index and CRC-low
// bytes give no beat. Synchronous reset returns the FSM to hunting with CRC at
// 0xFFFF. A stalled output beat stalls input only while the output register is
// full and not being drained.
`include "sync_frame_deframer_crc16_defines.svh"
module sync_frame_deframer_crc16 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] command, [15:8] start_index, [23:16] payload_length,
  // [31:24] data_byte, [32] crc_good, [39:33] zero
  output logic [sfd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [sfd_pkg::TUSER_W-1:0] m_axis_tuser,  // [1:0] out_kind
  output logic                        m_axis_tlast   // frame_last
);
  import sfd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_index, held_index_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic        in_fire;
  logic [15:0] crc_fed;
  logic [7:0]  left_dec;

  logic        emit;
  logic [1:0]  res_kind;
  logic [7:0]  res_data;
  logic        res_good;
  logic        res_last;

  logic        out_valid;
  logic [TDATA_W-1:0] out_data;
  logic [TUSER_W-1:0] out_user;
  logic        out_last;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign left_dec      = bytes_left - 8'd1;

  sfd_crc16_byte u_crc (
    .crc_in  (running_crc),
    .data    (s_axis_tdata),
    .crc_out (crc_fed)
  );

  // next state
  always_comb begin
    phase_next        = phase;
    running_crc_next  = running_crc;
    held_command_next = held_command;
    held_index_next   = held_index;
    held_length_next  = held_length;
    bytes_left_next   = bytes_left;
    crc_low_byte_next = crc_low_byte;
    if (in_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (s_axis_tdata == SYNC_FIRST) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          // a repeated first sync byte also drops back to hunting
          if (s_axis_tdata == SYNC_SECOND) begin
            phase_next       = PH_CMD;
            running_crc_next = CRC_INIT;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_CMD: begin
          held_command_next = s_axis_tdata;
          running_crc_next  = crc_fed;
          phase_next        = PH_INDEX;
        end
        PH_INDEX: begin
          held_index_next  = s_axis_tdata;
          running_crc_next = crc_fed;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          held_length_next = s_axis_tdata;
          bytes_left_next  = s_axis_tdata;
          running_crc_next = crc_fed;
          phase_next       = (s_axis_tdata == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_fed;
          bytes_left_next  = left_dec;
          if (left_dec == 8'd0) phase_next = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_low_byte_next = s_axis_tdata;
          phase_next        = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          running_crc_next = CRC_INIT;
          phase_next       = PH_HUNT;
        end
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    emit     = 1'b0;
    res_kind = KIND_HEADER;
    res_data = 8'd0;
    res_good = 1'b0;
    res_last = 1'b0;
    unique case (phase)
      PH_LEN: begin
        emit = 1'b1;
      end
      PH_PAYLOAD: begin
        emit     = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_data = s_axis_tdata;
      end
      PH_CRC_HI: begin
        emit     = 1'b1;
        res_kind = KIND_END;
        res_good = ({s_axis_tdata, crc_low_byte} == running_crc);
        res_last = 1'b1;
      end
      PH_HUNT, PH_SYNC2, PH_CMD, PH_INDEX, PH_CRC_LO: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      running_crc  <= CRC_INIT;
      held_command <= 8'd0;
      held_index   <= 8'd0;
      held_length  <= 8'd0;
      bytes_left   <= 8'd0;
      crc_low_byte <= 8'd0;
    end else begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      held_command <= held_command_next;
      held_index   <= held_index_next;
      held_length  <= held_length_next;
      bytes_left   <= bytes_left_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  // output register; the header fields are the values after this byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data <= {7'd0, res_good, res_data, held_length_next,
                   held_index_next, held_command_next};
      out_user <= res_kind;
      out_last <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

  `SFD_ASSERT(a_last_is_end, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_END))
  `SFD_ASSERT_ALWAYS(a_payload_count, (phase == PH_PAYLOAD) |-> (bytes_left != 8'd0))
  `SFD_ASSERT(a_len_to_payload,
    (in_fire && phase == PH_LEN && s_axis_tdata != 8'd0) |=> (phase == PH_PAYLOAD))

endmodule
